[sv/rwf_pkg.sv]
// Shared types, constants and register codes of the RGB 3x3 window filter.
`default_nettype none

package rwf_pkg;

    localparam int PIX_W        = 24;
    localparam int CHAN_W       = 8;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 13;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int RST_WIDTH      = 1024;
    localparam int RST_HEIGHT     = 768;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // Filter modes
    localparam logic [MODE_W-1:0] MODE_MEAN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VGRAD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HGRAD = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] pixel_b;
        logic [CHAN_W-1:0] pixel_g;
        logic [CHAN_W-1:0] pixel_r;
        logic              drain;
    } t_pix_req;

    typedef struct packed {
        logic [CHAN_W-1:0] out_b;
        logic [CHAN_W-1:0] out_g;
        logic [CHAN_W-1:0] out_r;
        logic              frame_last;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_req;

    // Per-request decisions made at accept time, carried into the compute stage
    typedef struct packed {
        logic drain;
        logic emit;
        logic border;
        logic last;
        logic sel_upper;
    } t_stage;

endpackage

`default_nettype wire

[sv/rwf_ifs.sv]
// Stream and configuration channel interfaces of the RGB 3x3 window filter.
`default_nettype none

interface rwf_pix_if import rwf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_pix_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rwf_res_if import rwf_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rwf_cfg_if import rwf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/rgb_3x3_window_filter.sv]
// Top of the RGB 3x3 window filter: 8-neighbour mean, row/column gradients per channel.
//
//  channel  dir  payload                                  handshake
//  i_pix    in   pixel_b, pixel_g, pixel_r, drain         valid/ready
//  o_res    out  out_b, out_g, out_r, frame_last          valid/ready
//  i_cfg    in   index (0 mode, 1 width, 2 height), data  valid/ready, ready high out of reset
//
// One request per clock unless o_res stalls; stage registers: compute, then result.
// Line stores are one memory of MAX_WIDTH words, one read and one write per cycle.
// A result leaves one row plus one pixel after its pixel; drains flush the tail.
// Synchronous reset clears counters, window and valids; no memory clearing pass.
// A stalled result holds the whole pipe; input ready drops only then and during reset.
`default_nettype none

module rgb_3x3_window_filter import rwf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rwf_pix_if.sink    i_pix,
    rwf_res_if.source  o_res,
    rwf_cfg_if.sink    i_cfg
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic               adv;
    logic               acc;
    logic               cfg_we;
    logic [MODE_W-1:0]  mode;
    t_stage             stage;
    logic [CW-1:0]      rd_addr;
    logic [2*PIX_W-1:0] rd_data;
    logic               wr_en;
    logic [CW-1:0]      wr_addr;
    logic [2*PIX_W-1:0] wr_data;

    assign i_pix.ready = adv && i_rst_n;
    assign i_cfg.ready = i_rst_n;
    assign acc         = i_pix.valid && i_pix.ready;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    rwf_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg     (i_cfg.data),
        .i_acc     (acc),
        .i_drain   (i_pix.data.drain),
        .o_mode    (mode),
        .o_stage   (stage),
        .o_rd_addr (rd_addr)
    );

    rwf_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (adv),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    rwf_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_pix       (i_pix.data),
        .i_stage     (stage),
        .i_rd_addr   (rd_addr),
        .i_mode      (mode),
        .i_rd_data   (rd_data),
        .o_adv       (adv),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_res_valid (o_res.valid),
        .o_res       (o_res.data),
        .i_res_ready (o_res.ready)
    );

endmodule

`default_nettype wire

[sv/rwf_line_mem.sv]
// Line store memory: upper and middle rows side by side, one write and one registered read.
`default_nettype none

module rwf_line_mem import rwf_pkg::*; #(
    parameter int DEPTH  = DEF_MAX_WIDTH,
    parameter int DATA_W = 2 * PIX_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]        o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/rwf_ctrl.sv]
// Configuration registers, raster counters, pending count and per-request decisions.
`default_nettype none

module rwf_ctrl import rwf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire t_cfg_req                     i_cfg,
    input  wire logic                         i_acc,
    input  wire logic                         i_drain,
    output logic      [MODE_W-1:0]            o_mode,
    output t_stage                            o_stage,
    output logic      [$clog2(MAX_WIDTH)-1:0] o_rd_addr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RST_W_EFF = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int RST_H_EFF = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

    logic [MODE_W-1:0] r_mode;
    logic [WW-1:0]     r_w;
    logic [HW-1:0]     r_h;
    logic [CW-1:0]     r_in_col,  n_in_col;
    logic [RW-1:0]     r_in_row,  n_in_row;
    logic [CW-1:0]     r_out_col, n_out_col;
    logic [RW-1:0]     r_out_row, n_out_row;
    logic [PW-1:0]     r_pend;

    logic [WIDTH_CFG_W-1:0]  cfg_w;
    logic [HEIGHT_CFG_W-1:0] cfg_h;
    logic [WW-1:0]           n_w;
    logic [HW-1:0]           n_h;
    logic                    full;
    logic                    out_adv;
    logic                    size_wr;

    assign cfg_w   = i_cfg.data[WIDTH_CFG_W-1:0];
    assign cfg_h   = i_cfg.data[HEIGHT_CFG_W-1:0];
    assign n_w     = (32'(cfg_w) < 32'd3) ? WW'(3) :
                     (32'(cfg_w) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_w);
    assign n_h     = (32'(cfg_h) < 32'd3) ? HW'(3) :
                     (32'(cfg_h) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_h);
    assign size_wr = i_cfg_we && (i_cfg.index == REG_WIDTH || i_cfg.index == REG_HEIGHT);

    assign full    = (r_pend == PW'(r_w) + PW'(1));
    assign out_adv = i_drain ? (r_pend != '0) : full;

    always_comb begin
        o_stage.drain     = i_drain;
        o_stage.emit      = out_adv;
        o_stage.sel_upper = full;
        o_stage.border    = (r_out_row == '0) || (HW'(r_out_row) == r_h - HW'(1))
                         || (r_out_col == '0) || (WW'(r_out_col) == r_w - WW'(1));
        o_stage.last      = (HW'(r_out_row) == r_h - HW'(1))
                         && (WW'(r_out_col) == r_w - WW'(1));
    end

    assign o_rd_addr = i_drain ? r_out_col : r_in_col;
    assign o_mode    = r_mode;

    // Raster advance for both counter pairs
    always_comb begin
        n_in_col  = r_in_col + CW'(1);
        n_in_row  = r_in_row;
        if (WW'(r_in_col) + WW'(1) >= r_w) begin
            n_in_col = '0;
            n_in_row = (HW'(r_in_row) + HW'(1) >= r_h) ? '0 : r_in_row + RW'(1);
        end
        n_out_col = r_out_col + CW'(1);
        n_out_row = r_out_row;
        if (WW'(r_out_col) + WW'(1) >= r_w) begin
            n_out_col = '0;
            n_out_row = (HW'(r_out_row) + HW'(1) >= r_h) ? '0 : r_out_row + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_MEAN;
            r_w       <= WW'(RST_W_EFF);
            r_h       <= HW'(RST_H_EFF);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
        end else begin
            if (i_cfg_we && i_cfg.index == REG_MODE) begin
                r_mode <= i_cfg.data[MODE_W-1:0];
            end
            if (i_cfg_we && i_cfg.index == REG_WIDTH) begin
                r_w <= n_w;
            end
            if (i_cfg_we && i_cfg.index == REG_HEIGHT) begin
                r_h <= n_h;
            end
            if (size_wr) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_pend    <= '0;
            end else if (i_acc) begin
                if (out_adv) begin
                    r_out_col <= n_out_col;
                    r_out_row <= n_out_row;
                end
                if (!i_drain) begin
                    r_in_col <= n_in_col;
                    r_in_row <= n_in_row;
                    if (!full) begin
                        r_pend <= r_pend + PW'(1);
                    end
                end else if (r_pend != '0) begin
                    r_pend <= r_pend - PW'(1);
                end
            end
        end
    end

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PW'(r_w) + PW'(1))
        else $error("pending count beyond one row plus one pixel");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_in_col) < r_w && WW'(r_out_col) < r_w)
        else $error("column counter outside the image width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        HW'(r_in_row) < r_h && HW'(r_out_row) < r_h)
        else $error("row counter outside the image height");

    a_size_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        size_wr |=> (r_pend == '0 && r_in_col == '0 && r_out_col == '0))
        else $error("size write did not restart the frame");

endmodule

`default_nettype wire

[sv/rwf_window.sv]
// Compute stage: window columns, line store update, filter arithmetic and result register.
`default_nettype none

module rwf_window import rwf_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_acc,
    input  wire t_pix_req                     i_pix,
    input  wire t_stage                       i_stage,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  wire logic [MODE_W-1:0]            i_mode,
    input  wire logic [2*PIX_W-1:0]           i_rd_data,
    output logic                              o_adv,
    output logic                              o_wr_en,
    output logic      [$clog2(MAX_WIDTH)-1:0] o_wr_addr,
    output logic      [2*PIX_W-1:0]           o_wr_data,
    output logic                              o_res_valid,
    output t_res                              o_res,
    input  wire logic                         i_res_ready
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic              r_b_valid;
    t_stage            r_b;
    logic [PIX_W-1:0]  r_b_pix;
    logic [CW-1:0]     r_b_addr;
    logic              r_fwd;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic [PIX_W-1:0]  r_wc [6];
    logic              r_o_valid;
    t_res              r_o;

    logic [2*PIX_W-1:0] mem_e;
    logic [PIX_W-1:0]   up_e;
    logic [PIX_W-1:0]   mid_e;
    logic               b_write;
    logic [PIX_W-1:0]   filt;
    logic [PIX_W-1:0]   res_px;

    assign o_adv   = !r_o_valid || i_res_ready;
    assign mem_e   = r_fwd ? r_fwd_data : i_rd_data;
    assign up_e    = mem_e[2*PIX_W-1:PIX_W];
    assign mid_e   = mem_e[PIX_W-1:0];
    assign b_write = r_b_valid && !r_b.drain;

    assign o_wr_en   = o_adv && b_write;
    assign o_wr_addr = r_b_addr;
    assign o_wr_data = {mid_e, r_b_pix};

    always_comb begin
        logic [CHAN_W-1:0] l0, l1, l2, m0, m2, q0, q1, q2;
        logic [10:0]       sum8;
        logic [9:0]        sa, sb, dif;
        filt = '0;
        for (int ch = 0; ch < 3; ch++) begin
            l0 = r_wc[0][ch*CHAN_W +: CHAN_W];
            l1 = r_wc[1][ch*CHAN_W +: CHAN_W];
            l2 = r_wc[2][ch*CHAN_W +: CHAN_W];
            m0 = r_wc[3][ch*CHAN_W +: CHAN_W];
            m2 = r_wc[5][ch*CHAN_W +: CHAN_W];
            q0 = up_e[ch*CHAN_W +: CHAN_W];
            q1 = mid_e[ch*CHAN_W +: CHAN_W];
            q2 = r_b_pix[ch*CHAN_W +: CHAN_W];
            sum8 = 11'(l0) + 11'(l1) + 11'(l2) + 11'(m0) + 11'(m2)
                 + 11'(q0) + 11'(q1) + 11'(q2);
            if (i_mode == MODE_VGRAD) begin
                sa = 10'(l2) + 10'(m2) + 10'(q2);
                sb = 10'(l0) + 10'(m0) + 10'(q0);
            end else begin
                sa = 10'(q0) + 10'(q1) + 10'(q2);
                sb = 10'(l0) + 10'(l1) + 10'(l2);
            end
            dif = (sa >= sb) ? sa - sb : sb - sa;
            if (i_mode == MODE_MEAN) begin
                filt[ch*CHAN_W +: CHAN_W] = sum8[10:3];
            end else begin
                filt[ch*CHAN_W +: CHAN_W] = (dif > 10'd255) ? 8'hFF : dif[CHAN_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_b.drain) begin
            res_px = r_b.sel_upper ? up_e : mid_e;
        end else if (r_b.border || i_mode > MODE_HGRAD) begin
            res_px = r_wc[4];
        end else begin
            res_px = filt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
            r_o_valid <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_wc[k] <= '0;
            end
        end else if (o_adv) begin
            r_b_valid <= i_acc;
            // Read and write of the same column at one edge: take the new word
            r_fwd     <= b_write && (r_b_addr == i_rd_addr);
            r_o_valid <= r_b_valid && r_b.emit;
            if (b_write) begin
                r_wc[0] <= r_wc[3];
                r_wc[1] <= r_wc[4];
                r_wc[2] <= r_wc[5];
                r_wc[3] <= up_e;
                r_wc[4] <= mid_e;
                r_wc[5] <= r_b_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_b        <= i_stage;
            r_b_pix    <= {i_pix.pixel_r, i_pix.pixel_g, i_pix.pixel_b};
            r_b_addr   <= i_rd_addr;
            r_fwd_data <= {mid_e, r_b_pix};
            r_o.out_b      <= res_px[CHAN_W-1:0];
            r_o.out_g      <= res_px[2*CHAN_W-1:CHAN_W];
            r_o.out_r      <= res_px[3*CHAN_W-1:2*CHAN_W];
            r_o.frame_last <= r_b.last;
        end
    end

    assign o_res_valid = r_o_valid;
    assign o_res       = r_o;

endmodule

`default_nettype wire
